[rtl/pac_pkg.sv]
// Shared types, widths and helpers for the polygon area and centroid block.
package pac_pkg;

    // Fixed field widths of the stream words
    localparam int COORD_W    = 16;
    localparam int AREA_W     = 42;
    localparam int MOM_W      = 60;
    localparam int CENT_W     = 24;
    localparam int QUO_W      = CENT_W + 1;
    localparam int DEN_W      = AREA_W + 1;
    localparam int STAT_W     = 2;
    localparam int IN_DATA_W  = 2 * COORD_W;
    localparam int OUT_DATA_W = 96;
    localparam int PAD_W      = OUT_DATA_W - AREA_W - 2 * CENT_W;

    // Centroid saturation limits (magnitudes)
    localparam logic [QUO_W-1:0]  CENT_POS_MAG = QUO_W'(25'h07F_FFFF);
    localparam logic [QUO_W-1:0]  CENT_NEG_MAG = QUO_W'(25'h080_0000);
    localparam logic [CENT_W-1:0] CENT_MAX     = 24'h7F_FFFF;
    localparam logic [CENT_W-1:0] CENT_MIN     = 24'h80_0000;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVER = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_E1,
        S_E2,
        S_E3,
        S_E4,
        S_E5,
        S_E6,
        S_CHK,
        S_PREP,
        S_DX_GO,
        S_DX_WAIT,
        S_DY_GO,
        S_DY_WAIT,
        S_FIN
    } state_t;

    // Divider result bundle
    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_res_t;

    // Apply sign and saturate a rounded quotient magnitude to the centroid range
    function automatic logic [CENT_W-1:0] sat_cent(input logic neg,
                                                   input logic [QUO_W-1:0] q,
                                                   input logic ovf);
        logic [QUO_W-1:0]  neg_q;
        logic [CENT_W-1:0] res;
        neg_q = -q;
        if (neg) begin
            if (ovf || (q > CENT_NEG_MAG)) begin
                res = CENT_MIN;
            end
            else begin
                res = neg_q[CENT_W-1:0];
            end
        end
        else begin
            if (ovf || (q > CENT_POS_MAG)) begin
                res = CENT_MAX;
            end
            else begin
                res = q[CENT_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

[rtl/pac_mul.sv]
// Shared signed multiplier with a registered product.
module pac_mul
    import pac_pkg::*;
#(
    parameter int A_W = 17,
    parameter int B_W = 33
)
(
    input  logic                   clk,
    input  logic signed [A_W-1:0]  a,
    input  logic signed [B_W-1:0]  b,
    output logic signed [A_W+B_W-1:0] prod
);

    logic signed [A_W+B_W-1:0] prod_reg;
    logic signed [A_W+B_W-1:0] prod_next;

    // Form the full-width product
    always_comb
    begin
        prod_next = (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end

    // Register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[rtl/pac_div.sv]
// Restoring divider, one quotient bit per cycle, with a sticky overflow flag.
module pac_div
    import pac_pkg::*;
#(
    parameter int NUM_W = 69
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_res_t         res
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    // Advance one quotient bit per busy cycle
    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg) begin
            num_next = num_reg << 1;
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            ovf_next = ovf_reg | quo_reg[QUO_W-1];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = quo_reg;

endmodule

[rtl/polygon_area_centroid_top.sv]
// Top level: shoelace area and centroid sequencer around a shared multiplier and divider.
//
//  channel  | dir | signals                              | word
//  ---------+-----+--------------------------------------+------------------------------------
//  s_axis   | in  | tvalid tready tdata[31:0] tlast      | vertex_x, vertex_y; tlast=last_vertex
//  m_axis   | out | tvalid tready tdata[95:0] tuser[1:0] | twice_area, centroid_x/y; tuser=status
//
//  A vertex takes an accept plus six multiplier steps (two cross terms, difference,
//  two moment products, last accumulate); the first vertex of a polygon is only accepted and stored.
//  The flagged vertex adds the closing edge, then, for a non-zero area, two divisions of
//  NUM_W steps each (NUM_W = 69 by default). Reset clears the sums and the sequencer
//  at once; there is no clearing pass. A waiting result does not hold up new vertices;
//  only a second result stalls until taken.
module polygon_area_centroid_top
    import pac_pkg::*;
#(
    parameter int MAX_VERTICES  = 1024,
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] vertex_x, [31:16] vertex_y
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [41:0] twice_area, [65:42] centroid_x,
                                                  // [89:66] centroid_y, [95:90] zero
    output logic [STAT_W-1:0]     m_axis_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 2);
    localparam int MA_W  = COORD_BITS + 1;
    localparam int MB_W  = 2 * COORD_BITS + 1;
    localparam int P_W   = MA_W + MB_W;
    localparam int NUM_W = MOM_W + FRACTION_BITS + 1;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] OVER_CNT = CNT_W'(MAX_VERTICES + 1);

    state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic                         last_reg;
    logic                         closing_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic signed [AREA_W-1:0]     area_reg;
    logic signed [MOM_W-1:0]      mx_reg, my_reg;
    logic signed [P_W-1:0]        t_reg;
    logic signed [MB_W-1:0]       c_reg;
    logic [AREA_W-1:0]            abs_area_reg;
    logic [MOM_W-1:0]             mag_x_reg, mag_y_reg;
    logic                         negx_reg, negy_reg;
    logic [DEN_W-1:0]             den_reg;
    status_t                      res_status_reg;
    logic [CENT_W-1:0]            cx_reg, cy_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [AREA_W-1:0]            out_area_reg;
    logic [CENT_W-1:0]            out_cx_reg, out_cy_reg;
    status_t                      out_status_reg;

    logic signed [COORD_BITS-1:0] in_x, in_y;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic                         s_acc, m_acc, take, fin_load;
    logic signed [MA_W-1:0]       mul_a;
    logic signed [MB_W-1:0]       mul_b;
    logic signed [P_W-1:0]        mul_prod;
    logic                         div_start;
    logic [NUM_W-1:0]             div_num;
    logic [MOM_W-1:0]             div_mag;
    div_res_t                     div_res;

    // Take the low coordinate bits as two's complement
    assign in_x = s_axis_tdata[COORD_BITS-1:0];
    assign in_y = s_axis_tdata[COORD_W+COORD_BITS-1:COORD_W];

    // Edge end points: previous vertex to current, or to first on the closing edge
    assign ax = prev_x_reg;
    assign ay = prev_y_reg;
    assign bx = closing_reg ? first_x_reg : cur_x_reg;
    assign by = closing_reg ? first_y_reg : cur_y_reg;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign m_acc    = m_axis_tvalid && m_axis_tready;
    assign take     = (cnt_reg < MAX_CNT);
    assign fin_load = (state_reg == S_FIN) && (!out_valid_reg || m_axis_tready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc) begin
                    if (take && (cnt_reg != '0)) begin
                        state_next = S_E1;
                    end
                    else if (s_axis_tlast) begin
                        state_next = take ? S_E1 : S_FIN;
                    end
                end
            end
            S_E1:      state_next = S_E2;
            S_E2:      state_next = S_E3;
            S_E3:      state_next = S_E4;
            S_E4:      state_next = S_E5;
            S_E5:      state_next = S_E6;
            S_E6:
            begin
                if (closing_reg) begin
                    state_next = S_CHK;
                end
                else if (last_reg) begin
                    state_next = S_E1;
                end
                else begin
                    state_next = S_IDLE;
                end
            end
            S_CHK:     state_next = (area_reg == '0) ? S_FIN : S_PREP;
            S_PREP:    state_next = S_DX_GO;
            S_DX_GO:   state_next = S_DX_WAIT;
            S_DX_WAIT: state_next = div_res.done ? S_DY_GO : S_DX_WAIT;
            S_DY_GO:   state_next = S_DY_WAIT;
            S_DY_WAIT: state_next = div_res.done ? S_FIN : S_DY_WAIT;
            S_FIN:     state_next = fin_load ? S_IDLE : S_FIN;
            default:   state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier operands, divider start
    always_comb
    begin
        s_axis_tready = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;
        div_mag       = mag_x_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_E1:
            begin
                mul_a = MA_W'(ax);
                mul_b = MB_W'(by);
            end
            S_E2:
            begin
                mul_a = MA_W'(bx);
                mul_b = MB_W'(ay);
            end
            S_E4:
            begin
                mul_a = MA_W'(ax) + MA_W'(bx);
                mul_b = c_reg;
            end
            S_E5:
            begin
                mul_a = MA_W'(ay) + MA_W'(by);
                mul_b = c_reg;
            end
            S_DX_GO:
            begin
                div_start = 1'b1;
            end
            S_DY_GO:
            begin
                div_start = 1'b1;
                div_mag   = mag_y_reg;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
        // Scaled numerator plus half the divisor gives round to nearest
        div_num = (NUM_W'(div_mag) << FRACTION_BITS) + NUM_W'(den_reg >> 1);
    end

    pac_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    pac_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .res   (div_res)
    );

    // Output valid: set on load, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_load) begin
            out_valid_next = 1'b1;
        end
        else if (m_acc) begin
            out_valid_next = 1'b0;
        end
    end

    // Sequencer, polygon state and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            closing_reg   <= 1'b0;
            last_reg      <= 1'b0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            area_reg      <= '0;
            mx_reg        <= '0;
            my_reg        <= '0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_acc) begin
                        last_reg    <= s_axis_tlast;
                        closing_reg <= !(take && (cnt_reg != '0));
                        if (take) begin
                            cnt_reg <= cnt_reg + 1'b1;
                            if (cnt_reg == '0) begin
                                first_x_reg <= in_x;
                                first_y_reg <= in_y;
                                prev_x_reg  <= in_x;
                                prev_y_reg  <= in_y;
                            end
                        end
                        else begin
                            cnt_reg <= OVER_CNT;
                        end
                    end
                end
                S_E4:
                begin
                    area_reg <= area_reg + AREA_W'(c_reg);
                end
                S_E5:
                begin
                    mx_reg <= mx_reg + MOM_W'(mul_prod);
                end
                S_E6:
                begin
                    my_reg <= my_reg + MOM_W'(mul_prod);
                    if (!closing_reg) begin
                        prev_x_reg <= cur_x_reg;
                        prev_y_reg <= cur_y_reg;
                        if (last_reg) begin
                            closing_reg <= 1'b1;
                        end
                    end
                end
                S_FIN:
                begin
                    // Clear for the next polygon once the result is handed on
                    if (fin_load) begin
                        cnt_reg     <= '0;
                        first_x_reg <= '0;
                        first_y_reg <= '0;
                        prev_x_reg  <= '0;
                        prev_y_reg  <= '0;
                        area_reg    <= '0;
                        mx_reg      <= '0;
                        my_reg      <= '0;
                    end
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // Edge temporaries, division operands and result staging
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc) begin
                    cur_x_reg      <= in_x;
                    cur_y_reg      <= in_y;
                    res_status_reg <= ST_OVER;
                end
            end
            S_E2:
            begin
                t_reg <= mul_prod;
            end
            S_E3:
            begin
                c_reg <= MB_W'(t_reg - mul_prod);
            end
            S_CHK:
            begin
                abs_area_reg   <= area_reg[AREA_W-1] ? AREA_W'(-area_reg) : AREA_W'(area_reg);
                mag_x_reg      <= mx_reg[MOM_W-1] ? MOM_W'(-mx_reg) : MOM_W'(mx_reg);
                mag_y_reg      <= my_reg[MOM_W-1] ? MOM_W'(-my_reg) : MOM_W'(my_reg);
                negx_reg       <= mx_reg[MOM_W-1] ^ area_reg[AREA_W-1];
                negy_reg       <= my_reg[MOM_W-1] ^ area_reg[AREA_W-1];
                res_status_reg <= (area_reg == '0) ? ST_ZERO : ST_OK;
            end
            S_PREP:
            begin
                // Three times the doubled area
                den_reg <= DEN_W'(abs_area_reg) + (DEN_W'(abs_area_reg) << 1);
            end
            S_DX_WAIT:
            begin
                if (div_res.done) begin
                    cx_reg <= sat_cent(negx_reg, div_res.quo, div_res.ovf);
                end
            end
            S_DY_WAIT:
            begin
                if (div_res.done) begin
                    cy_reg <= sat_cent(negy_reg, div_res.quo, div_res.ovf);
                end
            end
            S_FIN:
            begin
                if (fin_load) begin
                    out_status_reg <= res_status_reg;
                    if (res_status_reg == ST_OK) begin
                        out_area_reg <= AREA_W'(area_reg);
                        out_cx_reg   <= cx_reg;
                        out_cy_reg   <= cy_reg;
                    end
                    else begin
                        out_area_reg <= '0;
                        out_cx_reg   <= '0;
                        out_cy_reg   <= '0;
                    end
                end
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {PAD_W'(0), out_cy_reg, out_cx_reg, out_area_reg};
    assign m_axis_tuser  = out_status_reg;

`ifndef SYNTHESIS
    // A vertex that extends the polygon starts an edge straight away
    a_edge_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && take && (cnt_reg != '0)) |=> (state_reg == S_E1))
        else $error("edge sequence did not start after an accepted vertex");

    // An over-long polygon reports nothing but its status
    a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_OVER)) |->
        ((out_area_reg == '0) && (out_cx_reg == '0) && (out_cy_reg == '0)))
        else $error("non-zero result carried with the too-many-vertices status");

    // A new result word only appears from the final state
    a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result word raised outside the final state");
`endif

endmodule

[tb/polygon_area_centroid_top_tb.sv]
// Testbench for the shoelace polygon area and centroid block: directed and random polygons against a predictor.
`timescale 1ns / 1ps

module polygon_area_centroid_top_tb
    import pac_pkg::*;
();

    localparam int MAX_VERTS  = 1024;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int RAND_ITEMS = 950;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [15:0] vertex_x, [31:16] vertex_y
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [41:0] twice_area, [65:42] centroid_x,
                                                 // [89:66] centroid_y, [95:90] zero
    logic [STAT_W-1:0]     m_axis_tuser;         // [1:0] status

    // When set, neither side inserts gaps
    bit calm = 1'b0;

    polygon_area_centroid_top #(
        .MAX_VERTICES  (MAX_VERTS),
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // Shoelace predictor and store of pending polygon results
    class polygon_scoreboard;
        typedef struct {
            logic [AREA_W-1:0] area;
            logic [CENT_W-1:0] cent_x;
            logic [CENT_W-1:0] cent_y;
            status_t           status;
        } poly_result_t;

        longint      first_x, first_y, prev_x, prev_y;
        longint      area_sum, moment_x, moment_y;
        int unsigned vertex_count;
        poly_result_t polygon_q[$];
        int          errors;

        function new();
            errors = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            first_x = 0;
            first_y = 0;
            prev_x = 0;
            prev_y = 0;
            area_sum = 0;
            moment_x = 0;
            moment_y = 0;
            vertex_count = 0;
        endfunction

        function void add_edge(longint ax, longint ay, longint bx, longint by);
            longint c;
            c = ax * by - bx * ay;
            area_sum += c;
            moment_x += (ax + bx) * c;
            moment_y += (ay + by) * c;
        endfunction

        // Round num * 2^FRAC_BITS / den to nearest, ties away from zero, then saturate
        function longint centroid_fixed(longint num, longint den);
            bit                neg;
            longint unsigned   n, d, q, r, mag;
            neg = (num < 0);
            n = neg ? longint'(-num) : num;
            d = den;
            q = n / d;
            r = n % d;
            if (q >= (64'd1 << CENT_W))
            begin
                mag = 64'd1 << 32;
            end
            else
            begin
                mag = (q << FRAC_BITS) + (((r << FRAC_BITS) + d / 64'd2) / d);
            end
            if (neg)
            begin
                if (mag > 64'd8388608)
                    return -64'sd8388608;
                return -longint'(mag);
            end
            if (mag > 64'd8388607)
                return 64'sd8388607;
            return longint'(mag);
        endfunction

        // Advance the predictor by one accepted vertex word
        function void note_vertex(logic [COORD_W-1:0] x_raw, logic [COORD_W-1:0] y_raw,
                                  logic last);
            longint       x, y, d, sx, sy;
            poly_result_t res;
            x = longint'($signed(x_raw));
            y = longint'($signed(y_raw));
            if (vertex_count < MAX_VERTS)
            begin
                if (vertex_count == 0)
                begin
                    first_x = x;
                    first_y = y;
                end
                else
                begin
                    add_edge(prev_x, prev_y, x, y);
                end
                prev_x = x;
                prev_y = y;
                vertex_count++;
            end
            else
            begin
                vertex_count = MAX_VERTS + 1;
            end
            if (!last)
                return;

            res.area = '0;
            res.cent_x = '0;
            res.cent_y = '0;
            if (vertex_count > MAX_VERTS)
            begin
                res.status = ST_OVER;
            end
            else
            begin
                add_edge(prev_x, prev_y, first_x, first_y);
                if (area_sum == 0)
                begin
                    res.status = ST_ZERO;
                end
                else
                begin
                    d  = (area_sum < 0) ? -area_sum : area_sum;
                    sx = (area_sum < 0) ? -moment_x : moment_x;
                    sy = (area_sum < 0) ? -moment_y : moment_y;
                    res.status = ST_OK;
                    res.area   = AREA_W'(area_sum);
                    res.cent_x = CENT_W'(centroid_fixed(sx, 3 * d));
                    res.cent_y = CENT_W'(centroid_fixed(sy, 3 * d));
                end
            end
            polygon_q.push_back(res);
            clear_sums();
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void check_result(logic [OUT_DATA_W-1:0] data, logic [STAT_W-1:0] user);
            poly_result_t exp_r;
            logic [AREA_W-1:0] got_area;
            logic [CENT_W-1:0] got_cx, got_cy;
            got_area = data[AREA_W-1:0];
            got_cx   = data[AREA_W +: CENT_W];
            got_cy   = data[AREA_W + CENT_W +: CENT_W];
            if (polygon_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: area %0d cx %0d cy %0d status %0d",
                             $signed(got_area), $signed(got_cx), $signed(got_cy), user);
                return;
            end
            exp_r = polygon_q.pop_front();
            if (got_area !== exp_r.area || got_cx !== exp_r.cent_x ||
                got_cy !== exp_r.cent_y || user !== exp_r.status)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp/act: area %0d/%0d cx %0d/%0d cy %0d/%0d st %0d/%0d",
                             $signed(exp_r.area), $signed(got_area),
                             $signed(exp_r.cent_x), $signed(got_cx),
                             $signed(exp_r.cent_y), $signed(got_cy),
                             exp_r.status, user);
            end
        endfunction
    endclass

    polygon_scoreboard sb = new();

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h7FFE;
            default: return 16'h7FFF;
        endcase
    endfunction

    // Offer one vertex word and hold it until accepted
    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_vertex(x, y, last);
    endtask

    // Polygon of n vertices (four for the rectangle style) in one of several coordinate styles
    task automatic send_random_polygon(input int n, input int style, inout int sent);
        logic signed [COORD_W-1:0] x, y, x0, x1, y0, y1;
        int k;
        bit ccw;
        x0 = COORD_W'($urandom);
        x1 = COORD_W'($urandom);
        y0 = COORD_W'($urandom);
        y1 = COORD_W'($urandom);
        ccw = 1'($urandom_range(0, 1));
        if (style == 3)
            n = 4;
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0:
                begin
                    x = COORD_W'($urandom);
                    y = COORD_W'($urandom);
                end
                1:
                begin
                    x = COORD_W'($urandom_range(0, 40) - 20);
                    y = COORD_W'($urandom_range(0, 40) - 20);
                end
                2:
                begin
                    x = pick_extreme();
                    y = pick_extreme();
                end
                default:
                begin
                    // walk the rectangle corners in either direction
                    k = ccw ? i : 3 - i;
                    x = (k == 0 || k == 3) ? x0 : x1;
                    y = (k < 2) ? y0 : y1;
                end
            endcase
            send_vertex(x, y, i == n - 1);
            sent++;
        end
    endtask

    // Sink: take result words with random stalls
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                hold = pick_gap();
                m_axis_tready <= (hold == 0);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int sent;
        int n;
        int r;
        int w;
        sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single vertex: closing edge has no area
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b1);
        // small triangles, both orientations
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd10, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd10, 1'b1);
        send_vertex(16'sd0, 16'sd10, 1'b0);
        send_vertex(16'sd10, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd0, 1'b1);
        // full-range square
        send_vertex(-16'sd32768, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 1'b0);
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);
        // collinear points, zero area
        send_vertex(16'sd1, 16'sd1, 1'b0);
        send_vertex(16'sd2, 16'sd2, 1'b0);
        send_vertex(16'sd3, 16'sd3, 1'b1);
        // two vertices, zero area
        send_vertex(16'sd5, -16'sd7, 1'b0);
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);
        // near-cancelling bow tie drives the centroid into saturation
        send_vertex(-16'sd32768, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 1'b0);
        send_vertex(16'sd32767, -16'sd32768, 1'b0);
        send_vertex(-16'sd32768, 16'sd32766, 1'b1);
        // triangle with negative centroid
        send_vertex(-16'sd10, -16'sd10, 1'b0);
        send_vertex(-16'sd1, -16'sd10, 1'b0);
        send_vertex(-16'sd10, -16'sd1, 1'b1);

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            r = $urandom_range(0, 99);
            if (r < 10)
                n = $urandom_range(1, 2);
            else if (r < 85)
                n = $urandom_range(3, 8);
            else
                n = $urandom_range(9, 40);
            send_random_polygon(n, $urandom_range(0, 3), sent);
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        // drain outstanding results, then watch for strays
        for (w = 0; w < 20000 && sb.polygon_q.size() != 0; w++)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.polygon_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/pac_pkg.sv
rtl/pac_mul.sv
rtl/pac_div.sv
rtl/polygon_area_centroid_top.sv
tb/polygon_area_centroid_top_tb.sv
